// ----- sv/imsu_pkg.sv -----
// ----------------------------------------------------------------------------
// imsu_pkg
// Shared types, constants and helpers for the Ising Metropolis spin update.
// ----------------------------------------------------------------------------
package imsu_pkg;

   localparam int SIDE_DEFAULT = 32;

   localparam int COORD_W   = 5;
   localparam int RND_W     = 12;
   localparam int THR_W     = 12;
   localparam int THR_REG_W = 60;

   localparam int MAG_OUT_W  = 12;
   localparam int BOND_OUT_W = 13;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPT_UP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPT_DOWN = 2'd1;

   // A threshold of all ones means the flip is always taken.
   localparam logic [THR_W-1:0] THR_ALWAYS = 12'hFFF;

   typedef enum logic {
      REQ_UPDATE = 1'b0,
      REQ_SET    = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic flip;
      logic new_spin;
   } upd_status_type;

   // Reduce a 5-bit coordinate modulo the lattice side by restoring
   // subtraction, one quotient bit per step.
   function automatic logic [COORD_W-1:0] coord_mod(input logic [COORD_W-1:0] v,
                                                   input int side);
      int rem;
      rem = int'(v);
      for (int k = COORD_W - 1; k >= 0; k--) begin
         if (rem >= (side << k)) begin
            rem = rem - (side << k);
         end
      end
      return COORD_W'(rem);
   endfunction

endpackage

// ----- sv/imsu_ram.sv -----
// ----------------------------------------------------------------------------
// imsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imsu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         q_ff <= mem_ff[raddr];
      end
   end

   assign rdata = q_ff;

endmodule

// ----- sv/imsu_rows.sv -----
// ----------------------------------------------------------------------------
// imsu_rows
// Spin lattice stored as whole rows in three RAM copies, one per row read.
// Row valid bits give the all +1 reset, and a same-edge write is forwarded.
// ----------------------------------------------------------------------------
module imsu_rows import imsu_pkg::*; #(
   parameter int SIDE  = SIDE_DEFAULT,
   parameter int ROW_W = $clog2(SIDE_DEFAULT)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [ROW_W-1:0] rd_row_up,
   input  logic [ROW_W-1:0] rd_row_mid,
   input  logic [ROW_W-1:0] rd_row_dn,
   input  logic             wr_en,
   input  logic [ROW_W-1:0] wr_row,
   input  logic [SIDE-1:0]  wr_data,
   output logic [SIDE-1:0]  row_up,
   output logic [SIDE-1:0]  row_mid,
   output logic [SIDE-1:0]  row_dn
);

   localparam int NPORT = 3;

   logic [ROW_W-1:0] rd_addr [NPORT];
   logic [SIDE-1:0]  ram_q   [NPORT];
   logic [SIDE-1:0]  row_q   [NPORT];

   logic [SIDE-1:0]  row_valid_ff, row_valid_in;
   logic [NPORT-1:0] fwd_sel_ff, fwd_sel_in;
   logic [NPORT-1:0] hit_ff, hit_in;
   logic [SIDE-1:0]  fwd_data_ff, fwd_data_in;

   assign rd_addr[0] = rd_row_up;
   assign rd_addr[1] = rd_row_mid;
   assign rd_addr[2] = rd_row_dn;

   for (genvar i = 0; i < NPORT; i++) begin : g_port
      imsu_ram #(
         .WIDTH (SIDE),
         .DEPTH (SIDE)
      ) u_ram (
         .clock (clock),
         .we    (wr_en),
         .waddr (wr_row),
         .wdata (wr_data),
         .re    (rd_en),
         .raddr (rd_addr[i]),
         .rdata (ram_q[i])
      );

      // A row never written still holds its reset pattern of all +1.
      assign row_q[i] = fwd_sel_ff[i] ? fwd_data_ff :
                        (hit_ff[i] ? ram_q[i] : {SIDE{1'b1}});
   end

   assign row_up  = row_q[0];
   assign row_mid = row_q[1];
   assign row_dn  = row_q[2];

   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[wr_row] = 1'b1;
      end
      fwd_sel_in  = fwd_sel_ff;
      hit_in      = hit_ff;
      fwd_data_in = fwd_data_ff;
      if (rd_en) begin
         fwd_data_in = wr_data;
         for (int i = 0; i < NPORT; i++) begin
            fwd_sel_in[i] = wr_en && (wr_row == rd_addr[i]);
            hit_in[i]     = row_valid_ff[rd_addr[i]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         fwd_sel_ff   <= '0;
         hit_ff       <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
         fwd_sel_ff   <= fwd_sel_in;
         hit_ff       <= hit_in;
      end
      fwd_data_ff <= fwd_data_in;
   end

endmodule

// ----- sv/imsu_update.sv -----
// ----------------------------------------------------------------------------
// imsu_update
// Metropolis decision and set logic for one site, with the new row image
// and the incrementally updated magnetization and bond totals.
// ----------------------------------------------------------------------------
module imsu_update import imsu_pkg::*; #(
   parameter int SIDE   = SIDE_DEFAULT,
   parameter int ROW_W  = $clog2(SIDE_DEFAULT),
   parameter int MAG_W  = 12,
   parameter int BOND_W = 13
) (
   input  req_kind_type             req_kind,
   input  logic [RND_W-1:0]         rnd,
   input  logic                     want,
   input  logic [ROW_W-1:0]         col,
   input  logic [ROW_W-1:0]         col_lt,
   input  logic [ROW_W-1:0]         col_rt,
   input  logic [SIDE-1:0]          row_up,
   input  logic [SIDE-1:0]          row_mid,
   input  logic [SIDE-1:0]          row_dn,
   input  logic [THR_REG_W-1:0]     thr_up,
   input  logic [THR_REG_W-1:0]     thr_down,
   input  logic signed [MAG_W-1:0]  mag_cur,
   input  logic signed [BOND_W-1:0] bond_cur,
   output upd_status_type           status,
   output logic [SIDE-1:0]          row_new,
   output logic signed [MAG_W-1:0]  mag_new,
   output logic signed [BOND_W-1:0] bond_new
);

   logic                 spin;
   logic [2:0]           up_count;
   logic [THR_REG_W-1:0] thr_reg;
   logic [THR_W-1:0]     thr;
   logic                 flip;
   logic [BOND_W-1:0]    bond_step;

   always_comb begin
      spin     = row_mid[col];
      // Number of +1 neighbours; the neighbour sum is 2*count-4.
      up_count = 3'(row_up[col]) + 3'(row_dn[col]) + 3'(row_mid[col_lt])
               + 3'(row_mid[col_rt]);
      thr_reg  = spin ? thr_up : thr_down;
      thr      = thr_reg[THR_W*up_count +: THR_W];

      case (req_kind)
         REQ_UPDATE: flip = (thr == THR_ALWAYS) || (rnd < thr);
         REQ_SET:    flip = (want != spin);
         default:    flip = 1'b0;
      endcase

      status.flip     = flip;
      status.new_spin = spin ^ flip;

      row_new      = row_mid;
      row_new[col] = spin ^ flip;

      // Bond change is -2*s*(2*count-4), i.e. s*(8-4*count).
      bond_step = BOND_W'({up_count, 2'b00});
      mag_new   = mag_cur;
      bond_new  = bond_cur;
      if (flip) begin
         if (spin) begin
            mag_new  = mag_cur - MAG_W'(2);
            bond_new = bond_cur + BOND_W'(8) - bond_step;
         end else begin
            mag_new  = mag_cur + MAG_W'(2);
            bond_new = bond_cur + bond_step - BOND_W'(8);
         end
      end
   end

endmodule

// ----- sv/ising_metropolis_spin_update.sv -----
// A request is registered in the site stage, and its result in the response register.
// Throughput: one transaction per cycle while the response is not stalled; the
// spin rows come from a registered RAM read; a same-edge row write is forwarded.
// Reset (synchronous): row valid bits clear, so the lattice reads as all +1
// at once with no clearing pass; totals return to SIDE*SIDE and 2*SIDE*SIDE
// and both threshold registers to zero.
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Square Ising lattice with periodic wrap: Metropolis update or set of one
// site per transaction, returning running magnetization and bond sum.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update import imsu_pkg::*; #(
   parameter int SIDE = SIDE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // site_row[4:0], site_col[9:5], uniform_random[21:10], spin_value[22]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_row[4:0], out_col[9:5], new_spin[10], flipped[11],
   // total_magnetization[23:12], total_bond_sum[36:24]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THR_REG_W-1:0]   csr_wdata
);

   localparam int ROW_W  = $clog2(SIDE);
   localparam int SITES  = SIDE * SIDE;
   localparam int MAG_W  = $clog2(SITES) + 2;
   localparam int BOND_W = MAG_W + 1;
   localparam logic signed [MAG_W-1:0]  MAG_RESET  = MAG_W'(SITES);
   localparam logic signed [BOND_W-1:0] BOND_RESET = BOND_W'(2 * SITES);
   localparam logic [ROW_W-1:0]         LAST_IDX   = ROW_W'(SIDE - 1);
   localparam int PAD_W = RSP_TDATA_W - BOND_OUT_W - MAG_OUT_W - 2 - 2 * COORD_W;

   // Request decode and wrap.
   logic [ROW_W-1:0] in_row, in_row_up, in_row_dn;
   logic [ROW_W-1:0] in_col, in_col_lt, in_col_rt;
   logic             req_fire, s1_fire;

   // Site stage.
   logic             s1_valid_ff, s1_valid_in;
   req_kind_type     s1_kind_ff, s1_kind_in;
   logic [RND_W-1:0] s1_rnd_ff, s1_rnd_in;
   logic             s1_want_ff, s1_want_in;
   logic [ROW_W-1:0] s1_row_ff, s1_row_in;
   logic [ROW_W-1:0] s1_col_ff, s1_col_in;
   logic [ROW_W-1:0] s1_col_lt_ff, s1_col_lt_in;
   logic [ROW_W-1:0] s1_col_rt_ff, s1_col_rt_in;

   logic [SIDE-1:0]  row_up, row_mid, row_dn, row_new;
   upd_status_type   status;

   logic signed [MAG_W-1:0]  mag_ff, mag_in, mag_new;
   logic signed [BOND_W-1:0] bond_ff, bond_in, bond_new;
   logic [THR_REG_W-1:0]     thr_up_ff, thr_up_in, thr_down_ff, thr_down_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   always_comb begin
      in_row    = ROW_W'(coord_mod(req_tdata[4:0], SIDE));
      in_col    = ROW_W'(coord_mod(req_tdata[9:5], SIDE));
      in_row_up = (in_row == '0) ? LAST_IDX : in_row - ROW_W'(1);
      in_row_dn = (in_row == LAST_IDX) ? '0 : in_row + ROW_W'(1);
      in_col_lt = (in_col == '0) ? LAST_IDX : in_col - ROW_W'(1);
      in_col_rt = (in_col == LAST_IDX) ? '0 : in_col + ROW_W'(1);
   end

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s1_kind_in   = s1_kind_ff;
      s1_rnd_in    = s1_rnd_ff;
      s1_want_in   = s1_want_ff;
      s1_row_in    = s1_row_ff;
      s1_col_in    = s1_col_ff;
      s1_col_lt_in = s1_col_lt_ff;
      s1_col_rt_in = s1_col_rt_ff;
      if (req_fire) begin
         s1_kind_in   = req_kind_type'(req_tuser);
         s1_rnd_in    = req_tdata[21:10];
         s1_want_in   = req_tdata[22];
         s1_row_in    = in_row;
         s1_col_in    = in_col;
         s1_col_lt_in = in_col_lt;
         s1_col_rt_in = in_col_rt;
      end
   end

   imsu_rows #(
      .SIDE  (SIDE),
      .ROW_W (ROW_W)
   ) u_rows (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_fire),
      .rd_row_up  (in_row_up),
      .rd_row_mid (in_row),
      .rd_row_dn  (in_row_dn),
      .wr_en      (s1_fire && status.flip),
      .wr_row     (s1_row_ff),
      .wr_data    (row_new),
      .row_up     (row_up),
      .row_mid    (row_mid),
      .row_dn     (row_dn)
   );

   imsu_update #(
      .SIDE   (SIDE),
      .ROW_W  (ROW_W),
      .MAG_W  (MAG_W),
      .BOND_W (BOND_W)
   ) u_update (
      .req_kind (s1_kind_ff),
      .rnd      (s1_rnd_ff),
      .want     (s1_want_ff),
      .col      (s1_col_ff),
      .col_lt   (s1_col_lt_ff),
      .col_rt   (s1_col_rt_ff),
      .row_up   (row_up),
      .row_mid  (row_mid),
      .row_dn   (row_dn),
      .thr_up   (thr_up_ff),
      .thr_down (thr_down_ff),
      .mag_cur  (mag_ff),
      .bond_cur (bond_ff),
      .status   (status),
      .row_new  (row_new),
      .mag_new  (mag_new),
      .bond_new (bond_new)
   );

   always_comb begin
      mag_in       = s1_fire ? mag_new : mag_ff;
      bond_in      = s1_fire ? bond_new : bond_ff;
      thr_up_in    = thr_up_ff;
      thr_down_in  = thr_down_ff;
      if (csr_we && (csr_index == CSR_ACCEPT_UP)) begin
         thr_up_in = csr_wdata;
      end
      if (csr_we && (csr_index == CSR_ACCEPT_DOWN)) begin
         thr_down_in = csr_wdata;
      end

      rsp_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_data_ff;
      if (s1_fire) begin
         rsp_data_in = {PAD_W'(0), BOND_OUT_W'(bond_new), MAG_OUT_W'(mag_new),
                        status.flip, status.new_spin,
                        COORD_W'(s1_col_ff), COORD_W'(s1_row_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mag_ff       <= MAG_RESET;
         bond_ff      <= BOND_RESET;
         thr_up_ff    <= '0;
         thr_down_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mag_ff       <= mag_in;
         bond_ff      <= bond_in;
         thr_up_ff    <= thr_up_in;
         thr_down_ff  <= thr_down_in;
      end
      s1_kind_ff   <= s1_kind_in;
      s1_rnd_ff    <= s1_rnd_in;
      s1_want_ff   <= s1_want_in;
      s1_row_ff    <= s1_row_in;
      s1_col_ff    <= s1_col_in;
      s1_col_lt_ff <= s1_col_lt_in;
      s1_col_rt_ff <= s1_col_rt_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- sv/imsu_checker.sv -----
// ----------------------------------------------------------------------------
// imsu_checker
// Port-level checks on result ordering, totals parity and output holding.
// ----------------------------------------------------------------------------
module imsu_checker import imsu_pkg::*; #(
   parameter int SIDE = SIDE_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam logic       MAG_LSB  = 1'((SIDE * SIDE) % 2);
   localparam logic [1:0] BOND_LSB = 2'((2 * SIDE * SIDE) % 4);

   logic       in_fire, out_fire;
   logic [1:0] pend_ff, pend_in;

   assign in_fire  = req_tvalid && req_tready;
   assign out_fire = rsp_tvalid && rsp_tready;

   always_comb begin
      pend_in = pend_ff + 2'(in_fire) - 2'(out_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Every result belongs to a request that is still outstanding.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pend_ff != 2'd0))
      else $error("result shown with no outstanding request");

   // Each flip moves magnetization by two and the bond sum by a multiple of four.
   a_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[12] == MAG_LSB) && (rsp_tdata[25:24] == BOND_LSB)))
      else $error("totals lost their parity");

   // Back-to-back results without a flip leave both totals unchanged.
   a_no_flip_stable: assert property (@(posedge clock) disable iff (reset)
      (out_fire ##1 (out_fire && !rsp_tdata[11])) |->
         (rsp_tdata[36:12] == $past(rsp_tdata[36:12])))
      else $error("totals changed without a flip");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result dropped or changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind ising_metropolis_spin_update imsu_checker #(
   .SIDE (SIDE)
) u_imsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
